/* sv/ffha_pkg.sv */
`default_nettype none
package ffha_pkg;

  localparam int HEAP_BYTES      = 65536;
  localparam int HEADER_BYTES    = 24;
  localparam int MIN_SPLIT_BYTES = 16;
  localparam int ALIGN_BYTES     = 8;
  localparam int PAGE_BYTES      = 4096;

  localparam int MAX_PAGES = HEAP_BYTES / PAGE_BYTES;
  localparam int DEPTH     = HEAP_BYTES / ALIGN_BYTES;
  localparam int AW        = $clog2(DEPTH);
  localparam int OW        = $clog2(HEAP_BYTES) + 1;
  localparam int ALIGN_SH  = $clog2(ALIGN_BYTES);
  localparam int PAGE_SH   = $clog2(PAGE_BYTES);
  localparam int SPLIT_MIN = HEADER_BYTES + MIN_SPLIT_BYTES;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_ZERO    = 3'd1,
    ST_OOM     = 3'd2,
    ST_NULL    = 3'd3,
    ST_INVALID = 3'd4,
    ST_DOUBLE  = 3'd5
  } status_t;

  localparam logic [1:0] ACT_INIT  = 2'd0;
  localparam logic [1:0] ACT_ALLOC = 2'd1;
  localparam logic [1:0] ACT_FREE  = 2'd2;

  // One block header: free mark and data size
  typedef struct packed {
    logic        free;
    logic [15:0] size;
  } hdr_t;

  typedef struct packed {
    logic          rd_en;
    logic [AW-1:0] rd_addr;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    hdr_t          wr_data;
  } mem_req_t;

  function automatic logic [AW-1:0] slot(input logic [OW:0] off);
    slot = off[AW+ALIGN_SH-1:ALIGN_SH];
  endfunction

endpackage
`default_nettype wire

/* sv/ffha_hdr_mem.sv */
`default_nettype none
module ffha_hdr_mem
  import ffha_pkg::*;
(
  input  wire logic     clk,
  input  wire mem_req_t req,
  output hdr_t          rdata
);

  hdr_t mem [DEPTH];
  hdr_t rdata_r;

  // Write one header
  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
  end

  // Registered read
  always_ff @(posedge clk) begin
    if (req.rd_en) begin
      rdata_r <= mem[req.rd_addr];
    end
  end

  assign rdata = rdata_r;

endmodule
`default_nettype wire

/* sv/ffha_seq.sv */
`default_nettype none
module ffha_seq
  import ffha_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic [4:0]  pages,
  input  wire logic        start,
  input  wire logic [1:0]  in_action,
  input  wire logic [15:0] in_request_size,
  input  wire logic [15:0] in_address,
  output logic             busy,
  output logic             out_valid,
  output logic [2:0]       out_status,
  output logic [15:0]      out_data_offset,
  output logic [15:0]      out_granted_size,
  output logic [16:0]      out_bytes_in_use,
  output mem_req_t         mreq,
  input  wire hdr_t        rdata
);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_ACK  = 5'b00010,
    S_AWR  = 5'b00100,
    S_FCK  = 5'b01000,
    S_MCK  = 5'b10000
  } state_t;

  state_t        state_r, state_nxt;
  logic [OW-1:0] off_r, off_nxt, need_r, need_nxt, hdr_r, hdr_nxt;
  logic [OW-1:0] sz_r, sz_nxt, heap_r, heap_nxt, total_r, total_nxt;
  logic [15:0]   gr_r, gr_nxt;

  logic          rsp_v;
  status_t       rsp_st;
  logic [15:0]   rsp_data, rsp_gr;

  logic          out_valid_r;
  logic [2:0]    out_status_r;
  logic [15:0]   out_data_r, out_gr_r;
  logic [16:0]   out_total_r;

  logic [OW-1:0] need_c, heap_c, hdr_c, addr_x, szx, rest;
  logic [4:0]    pg;
  logic [OW:0]   noff, jofs, nxt_c, s2;

  always_comb begin
    state_nxt = state_r;
    off_nxt   = off_r;
    need_nxt  = need_r;
    hdr_nxt   = hdr_r;
    sz_nxt    = sz_r;
    heap_nxt  = heap_r;
    total_nxt = total_r;
    gr_nxt    = gr_r;
    rsp_v     = 1'b0;
    rsp_st    = ST_OK;
    rsp_data  = '0;
    rsp_gr    = '0;
    mreq      = '0;

    need_c = (OW'(in_request_size) + OW'(ALIGN_BYTES - 1)) & ~OW'(ALIGN_BYTES - 1);
    if (pages == 5'd0) begin
      pg = 5'd1;
    end else if (pages > 5'(MAX_PAGES)) begin
      pg = 5'(MAX_PAGES);
    end else begin
      pg = pages;
    end
    heap_c = OW'(pg) << PAGE_SH;
    addr_x = OW'(in_address);
    hdr_c  = addr_x - OW'(HEADER_BYTES);
    szx    = OW'(rdata.size);
    rest   = szx - need_r;
    noff   = {1'b0, off_r} + (OW+1)'(HEADER_BYTES) + {1'b0, szx};
    jofs   = {1'b0, off_r} + (OW+1)'(HEADER_BYTES) + {1'b0, need_r};
    nxt_c  = {1'b0, hdr_r} + (OW+1)'(HEADER_BYTES) + {1'b0, szx};
    s2     = {1'b0, sz_r} + (OW+1)'(HEADER_BYTES) + {1'b0, szx};

    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          unique case (in_action)
            ACT_INIT: begin
              // Format one free block over the whole heap
              mreq.wr_en   = 1'b1;
              mreq.wr_addr = '0;
              mreq.wr_data = '{free: 1'b1, size: 16'(heap_c - OW'(HEADER_BYTES))};
              heap_nxt     = heap_c;
              total_nxt    = '0;
              rsp_v        = 1'b1;
            end
            ACT_ALLOC: begin
              rsp_v = 1'b1;
              if (in_request_size == 16'd0) begin
                rsp_st = ST_ZERO;
              end else if (heap_r == '0) begin
                rsp_st = ST_OOM;
              end else begin
                rsp_v        = 1'b0;
                mreq.rd_en   = 1'b1;
                mreq.rd_addr = '0;
                off_nxt      = '0;
                need_nxt     = need_c;
                state_nxt    = S_ACK;
              end
            end
            ACT_FREE: begin
              rsp_v = 1'b1;
              priority if (in_address == 16'd0) begin
                rsp_st = ST_NULL;
              end else if (addr_x < OW'(HEADER_BYTES) || hdr_c >= heap_r ||
                           hdr_c[ALIGN_SH-1:0] != '0) begin
                rsp_st = ST_INVALID;
              end else begin
                rsp_v        = 1'b0;
                mreq.rd_en   = 1'b1;
                mreq.rd_addr = '0;
                off_nxt      = '0;
                hdr_nxt      = hdr_c;
                state_nxt    = S_FCK;
              end
            end
            default: begin
              rsp_v = 1'b1;
            end
          endcase
        end
      end

      S_ACK: begin
        // Walk headers until a free block fits
        if (rdata.free && szx >= need_r) begin
          if (rest > OW'(SPLIT_MIN)) begin
            mreq.wr_en   = 1'b1;
            mreq.wr_addr = slot(jofs);
            mreq.wr_data = '{free: 1'b1, size: 16'(rest - OW'(HEADER_BYTES))};
            state_nxt    = S_AWR;
          end else begin
            mreq.wr_en   = 1'b1;
            mreq.wr_addr = slot({1'b0, off_r});
            mreq.wr_data = '{free: 1'b0, size: rdata.size};
            total_nxt    = total_r + szx;
            rsp_v        = 1'b1;
            rsp_data     = 16'(off_r + OW'(HEADER_BYTES));
            rsp_gr       = rdata.size;
            state_nxt    = S_IDLE;
          end
        end else if (noff < {1'b0, heap_r}) begin
          mreq.rd_en   = 1'b1;
          mreq.rd_addr = slot(noff);
          off_nxt      = noff[OW-1:0];
        end else begin
          rsp_v     = 1'b1;
          rsp_st    = ST_OOM;
          state_nxt = S_IDLE;
        end
      end

      S_AWR: begin
        // Shrink the granted block to the request
        mreq.wr_en   = 1'b1;
        mreq.wr_addr = slot({1'b0, off_r});
        mreq.wr_data = '{free: 1'b0, size: need_r[15:0]};
        total_nxt    = total_r + need_r;
        rsp_v        = 1'b1;
        rsp_data     = 16'(off_r + OW'(HEADER_BYTES));
        rsp_gr       = need_r[15:0];
        state_nxt    = S_IDLE;
      end

      S_FCK: begin
        // Walk the chain to the header being freed
        if (off_r == hdr_r) begin
          if (rdata.free) begin
            rsp_v     = 1'b1;
            rsp_st    = ST_DOUBLE;
            state_nxt = S_IDLE;
          end else begin
            total_nxt = total_r - szx;
            gr_nxt    = rdata.size;
            sz_nxt    = szx;
            if (nxt_c < {1'b0, heap_r}) begin
              mreq.rd_en   = 1'b1;
              mreq.rd_addr = slot(nxt_c);
              state_nxt    = S_MCK;
            end else begin
              mreq.wr_en   = 1'b1;
              mreq.wr_addr = slot({1'b0, hdr_r});
              mreq.wr_data = '{free: 1'b1, size: rdata.size};
              rsp_v        = 1'b1;
              rsp_gr       = rdata.size;
              state_nxt    = S_IDLE;
            end
          end
        end else if (noff < {1'b0, heap_r} && noff <= {1'b0, hdr_r}) begin
          mreq.rd_en   = 1'b1;
          mreq.rd_addr = slot(noff);
          off_nxt      = noff[OW-1:0];
        end else begin
          rsp_v     = 1'b1;
          rsp_st    = ST_INVALID;
          state_nxt = S_IDLE;
        end
      end

      S_MCK: begin
        // Absorb following free blocks
        if (rdata.free) begin
          sz_nxt = s2[OW-1:0];
          if (({1'b0, hdr_r} + (OW+1)'(HEADER_BYTES) + s2) < {1'b0, heap_r}) begin
            mreq.rd_en   = 1'b1;
            mreq.rd_addr = slot({1'b0, hdr_r} + (OW+1)'(HEADER_BYTES) + s2);
          end else begin
            mreq.wr_en   = 1'b1;
            mreq.wr_addr = slot({1'b0, hdr_r});
            mreq.wr_data = '{free: 1'b1, size: s2[15:0]};
            rsp_v        = 1'b1;
            rsp_gr       = gr_r;
            state_nxt    = S_IDLE;
          end
        end else begin
          mreq.wr_en   = 1'b1;
          mreq.wr_addr = slot({1'b0, hdr_r});
          mreq.wr_data = '{free: 1'b1, size: sz_r[15:0]};
          rsp_v        = 1'b1;
          rsp_gr       = gr_r;
          state_nxt    = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      heap_r      <= '0;
      total_r     <= '0;
      out_valid_r <= 1'b0;
      out_total_r <= '0;
    end else begin
      state_r     <= state_nxt;
      heap_r      <= heap_nxt;
      total_r     <= total_nxt;
      out_valid_r <= rsp_v;
      if (rsp_v) begin
        out_total_r <= 17'(total_nxt);
      end
    end
  end

  // Walk registers and result payload
  always_ff @(posedge clk) begin
    off_r  <= off_nxt;
    need_r <= need_nxt;
    hdr_r  <= hdr_nxt;
    sz_r   <= sz_nxt;
    gr_r   <= gr_nxt;
    if (rsp_v) begin
      out_status_r <= rsp_st;
      out_data_r   <= (rsp_st == ST_OK) ? rsp_data : 16'd0;
      out_gr_r     <= (rsp_st == ST_OK) ? rsp_gr : 16'd0;
    end
  end

  assign busy             = (state_r != S_IDLE);
  assign out_valid        = out_valid_r;
  assign out_status       = out_status_r;
  assign out_data_offset  = out_data_r;
  assign out_granted_size = out_gr_r;
  assign out_bytes_in_use = out_total_r;

endmodule
`default_nettype wire

/* sv/first_fit_heap_allocator.sv */
// First-fit heap allocator with forward coalescing.
// Requests: pulse start with in_action (init, allocate, free), in_request_size
// and in_address while busy is low. Exactly one result per request appears on
// the out_ ports for one cycle, marked by out_valid; the receiver cannot stall.
// Init, action 3 and early rejects answer in the cycle after start.
// Allocate reads headers in S_ACK until a free block fits, writes it and
// answers, passing through S_AWR when the block is split. Free walks the
// chain headers before the freed one in S_FCK, then merges the following
// free blocks in S_MCK until an allocated block or the heap end is reached.
// Each header visited costs one read of the header memory (8192 entries,
// registered read port); the walk issues the next read from the header
// just returned, so the header chain sets the rate. One request at a time.
// cfg_heap_pages is written through cfg_valid/cfg_ready while idle and is
// applied at the next init request.
// Reset: heap unformatted (allocate answers out of memory, free answers
// invalid address), total cleared, heap_pages = 16. Header memory is not
// cleared; init formats it.
`default_nettype none
module first_fit_heap_allocator
  import ffha_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [1:0]  in_action,
  input  wire logic [15:0] in_request_size,
  input  wire logic [15:0] in_address,
  output logic             out_valid,
  output logic [2:0]       out_status,
  output logic [15:0]      out_data_offset,
  output logic [15:0]      out_granted_size,
  output logic [16:0]      out_bytes_in_use,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [4:0]  cfg_heap_pages
);

  logic [4:0] pages_r;
  mem_req_t   mreq;
  hdr_t       rdata;

  // Hold the page count register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pages_r <= 5'(MAX_PAGES);
    end else if (cfg_valid && cfg_ready) begin
      pages_r <= cfg_heap_pages;
    end
  end

  assign cfg_ready = !busy;

  ffha_seq u_seq (
    .clk              (clk),
    .rst_n            (rst_n),
    .pages            (pages_r),
    .start            (start),
    .in_action        (in_action),
    .in_request_size  (in_request_size),
    .in_address       (in_address),
    .busy             (busy),
    .out_valid        (out_valid),
    .out_status       (out_status),
    .out_data_offset  (out_data_offset),
    .out_granted_size (out_granted_size),
    .out_bytes_in_use (out_bytes_in_use),
    .mreq             (mreq),
    .rdata            (rdata)
  );

  ffha_hdr_mem u_mem (
    .clk  (clk),
    .req  (mreq),
    .rdata(rdata)
  );

endmodule
`default_nettype wire

/* sv/ffha_chk.sv */
`default_nettype none
module ffha_chk
  import ffha_pkg::*;
(
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        start,
  input wire logic        busy,
  input wire logic        out_valid,
  input wire logic [2:0]  out_status,
  input wire logic [15:0] out_data_offset,
  input wire logic [15:0] out_granted_size,
  input wire logic [16:0] out_bytes_in_use
);

  // An accepted request either answers next cycle or keeps the block busy
  a_accept_progress: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> (busy || out_valid))
    else $error("accepted request neither answered nor in progress");

  // Failures carry no offset and no size
  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status != ST_OK) |->
      (out_data_offset == 16'd0 && out_granted_size == 16'd0))
    else $error("failed request returned offset or size");

  // Granted data areas are aligned
  a_aligned: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == ST_OK) |->
      (out_data_offset[ALIGN_SH-1:0] == '0))
    else $error("misaligned data offset");

  // Total only moves with a result
  a_total_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> $stable(out_bytes_in_use))
    else $error("allocated total changed without a result");

endmodule

bind first_fit_heap_allocator ffha_chk u_chk (
  .clk              (clk),
  .rst_n            (rst_n),
  .start            (start),
  .busy             (busy),
  .out_valid        (out_valid),
  .out_status       (out_status),
  .out_data_offset  (out_data_offset),
  .out_granted_size (out_granted_size),
  .out_bytes_in_use (out_bytes_in_use)
);
`default_nettype wire

/* tb/tb.sv */
`timescale 1ns / 1ps
module tb
  import ffha_pkg::*;
();

  localparam logic [1:0] ACT_NONE = 2'd3;
  localparam int         SLOTS    = HEAP_BYTES / ALIGN_BYTES;

  typedef struct {
    status_t     status;
    logic [15:0] data_offset;
    logic [15:0] granted_size;
    logic [16:0] bytes_in_use;
  } heap_result_t;

  typedef struct {
    logic [1:0]  action;
    logic [15:0] req;
    logic [15:0] addr;
    bit          fixed;
    status_t     status;
    logic [15:0] data_offset;
    logic [15:0] granted_size;
  } heap_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [1:0]  in_action = ACT_INIT;
  logic [15:0] in_request_size = '0;
  logic [15:0] in_address = '0;
  logic        out_valid;
  logic [2:0]  out_status;
  logic [15:0] out_data_offset;
  logic [15:0] out_granted_size;
  logic [16:0] out_bytes_in_use;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [4:0]  cfg_heap_pages = '0;

  // Shadow heap: per-header size, free and live marks
  int unsigned blk_size [SLOTS];
  bit          blk_free [SLOTS];
  bit          blk_live [SLOTS];
  int unsigned heap_len;
  int unsigned alloc_sum;
  int unsigned page_cfg;

  heap_result_t pending_q[$];
  logic [15:0]  live_ptrs[$];
  logic [15:0]  freed_ptrs[$];
  bit           idle_on = 1'b1;
  bit           failed = 1'b0;

  first_fit_heap_allocator i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_action        (in_action),
    .in_request_size  (in_request_size),
    .in_address       (in_address),
    .out_valid        (out_valid),
    .out_status       (out_status),
    .out_data_offset  (out_data_offset),
    .out_granted_size (out_granted_size),
    .out_bytes_in_use (out_bytes_in_use),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_heap_pages   (cfg_heap_pages)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  initial begin
    #300ms;
    $display("first_fit_heap_allocator verification failed");
    $finish;
  end

  function automatic int unsigned hdr_slot(int unsigned off);
    return (off / ALIGN_BYTES) % SLOTS;
  endfunction

  function automatic bit chain_has(int unsigned hdr);
    int unsigned off;
    off = 0;
    while (off < heap_len && off < hdr) off += HEADER_BYTES + blk_size[hdr_slot(off)];
    return off == hdr;
  endfunction

  // Advance the shadow heap by one request and return its result
  function automatic heap_result_t heap_step(logic [1:0] act, logic [15:0] req,
                                             logic [15:0] addr);
    heap_result_t r;
    int unsigned  pages, need, off, i, j, sz, rest, hdr, nxt;
    bit           found;
    r.status = ST_OK;
    r.data_offset = '0;
    r.granted_size = '0;
    if (act == ACT_INIT) begin
      pages = (page_cfg == 0) ? 1 : page_cfg;
      if (pages > MAX_PAGES) pages = MAX_PAGES;
      heap_len = pages * PAGE_BYTES;
      foreach (blk_live[k]) blk_live[k] = 1'b0;
      blk_size[0] = heap_len - HEADER_BYTES;
      blk_free[0] = 1'b1;
      blk_live[0] = 1'b1;
      alloc_sum = 0;
    end else if (act == ACT_ALLOC) begin
      if (req == 0) begin
        r.status = ST_ZERO;
      end else begin
        need = ((req + ALIGN_BYTES - 1) / ALIGN_BYTES) * ALIGN_BYTES;
        off = 0;
        found = 1'b0;
        while (!found && off < heap_len) begin
          i = hdr_slot(off);
          sz = blk_size[i];
          if (blk_free[i] && sz >= need) begin
            rest = sz - need;
            if (rest > SPLIT_MIN) begin
              j = hdr_slot(off + HEADER_BYTES + need);
              blk_size[j] = rest - HEADER_BYTES;
              blk_free[j] = 1'b1;
              blk_live[j] = 1'b1;
              sz = need;
              blk_size[i] = sz;
            end
            blk_free[i] = 1'b0;
            alloc_sum += sz;
            r.data_offset = 16'(off + HEADER_BYTES);
            r.granted_size = 16'(sz);
            found = 1'b1;
          end else begin
            off += HEADER_BYTES + sz;
          end
        end
        if (!found) r.status = ST_OOM;
      end
    end else if (act == ACT_FREE) begin
      hdr = addr - HEADER_BYTES;
      if (addr == 0) r.status = ST_NULL;
      else if (addr < HEADER_BYTES || hdr >= heap_len) r.status = ST_INVALID;
      else if (!blk_live[hdr_slot(hdr)] || !chain_has(hdr)) r.status = ST_INVALID;
      else if (blk_free[hdr_slot(hdr)]) r.status = ST_DOUBLE;
      else begin
        i = hdr_slot(hdr);
        sz = blk_size[i];
        r.granted_size = 16'(sz);
        blk_free[i] = 1'b1;
        alloc_sum -= sz;
        nxt = hdr + HEADER_BYTES + sz;
        while (nxt < heap_len && blk_free[hdr_slot(nxt)]) begin
          j = hdr_slot(nxt);
          sz += HEADER_BYTES + blk_size[j];
          blk_live[j] = 1'b0;
          nxt = hdr + HEADER_BYTES + sz;
        end
        blk_size[i] = sz;
      end
    end
    r.bytes_in_use = 17'(alloc_sum);
    return r;
  endfunction

  // Present one request, hold it until accepted, then log its expected result
  task automatic issue(logic [1:0] act, logic [15:0] req, logic [15:0] addr,
                       bit fixed = 1'b0, status_t st = ST_OK,
                       logic [15:0] doff = '0, logic [15:0] gsz = '0);
    heap_result_t r;
    start <= 1'b1;
    in_action <= act;
    in_request_size <= req;
    in_address <= addr;
    do @(posedge clk); while (busy);
    r = heap_step(act, req, addr);
    if (act == ACT_INIT) begin
      live_ptrs.delete();
      freed_ptrs.delete();
    end else if (r.status == ST_OK && act == ACT_ALLOC) begin
      live_ptrs.push_back(r.data_offset);
    end
    if (fixed) begin
      r.status = st;
      r.data_offset = doff;
      r.granted_size = gsz;
    end
    pending_q.push_back(r);
    if (idle_on && $urandom_range(99) < 27) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
  endtask

  // Hold off requests until every result is back
  task automatic drain();
    start <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_pages(logic [4:0] v);
    drain();
    cfg_valid <= 1'b1;
    cfg_heap_pages <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    page_cfg = v;
  endtask

  // Check each result against the oldest expectation
  always @(posedge clk) begin
    heap_result_t e;
    if (rst_n && out_valid) begin
      if (pending_q.size() == 0) begin
        $error("unexpected result status=%0d", out_status);
        failed = 1'b1;
      end else begin
        e = pending_q.pop_front();
        if (out_status !== e.status) begin
          $error("status expected %0d got %0d", e.status, out_status);
          failed = 1'b1;
        end
        if (out_data_offset !== e.data_offset) begin
          $error("data_offset expected %0d got %0d", e.data_offset, out_data_offset);
          failed = 1'b1;
        end
        if (out_granted_size !== e.granted_size) begin
          $error("granted_size expected %0d got %0d", e.granted_size, out_granted_size);
          failed = 1'b1;
        end
        if (out_bytes_in_use !== e.bytes_in_use) begin
          $error("bytes_in_use expected %0d got %0d", e.bytes_in_use,
                 out_bytes_in_use);
          failed = 1'b1;
        end
      end
    end
  end

  // Random free: mostly live pointers, some stale, skewed or arbitrary
  task automatic random_free();
    int unsigned pick, k;
    logic [15:0] a;
    pick = $urandom_range(99);
    if (pick < 60 && live_ptrs.size() != 0) begin
      k = $urandom_range(live_ptrs.size() - 1);
      a = live_ptrs[k];
      live_ptrs.delete(k);
      freed_ptrs.push_back(a);
      if (freed_ptrs.size() > 8) void'(freed_ptrs.pop_front());
    end else if (pick < 70 && freed_ptrs.size() != 0) begin
      a = freed_ptrs[$urandom_range(freed_ptrs.size() - 1)];
    end else if (pick < 85 && live_ptrs.size() != 0) begin
      a = live_ptrs[$urandom_range(live_ptrs.size() - 1)] +
          16'($urandom_range(1, 40)) - 16'd20;
    end else begin
      a = 16'($urandom);
    end
    issue(ACT_FREE, 16'($urandom), a);
  endtask

  task automatic random_alloc();
    int unsigned pick;
    logic [15:0] sz;
    pick = $urandom_range(99);
    if (pick < 70) sz = 16'($urandom_range(1, 128));
    else if (pick < 90) sz = 16'($urandom_range(1, 4096));
    else sz = 16'($urandom);
    issue(ACT_ALLOC, sz, 16'($urandom));
  endtask

  heap_row_t plan[] = '{
    '{ACT_ALLOC, 16'd16,    16'd0,     1'b1, ST_OOM,     16'd0,  16'd0},
    '{ACT_FREE,  16'd0,     16'd100,   1'b1, ST_INVALID, 16'd0,  16'd0},
    '{ACT_FREE,  16'd0,     16'd0,     1'b1, ST_NULL,    16'd0,  16'd0},
    '{ACT_NONE,  16'hffff,  16'hffff,  1'b1, ST_OK,      16'd0,  16'd0},
    '{ACT_INIT,  16'hffff,  16'hffff,  1'b1, ST_OK,      16'd0,  16'd0},
    '{ACT_ALLOC, 16'd0,     16'd0,     1'b1, ST_ZERO,    16'd0,  16'd0},
    '{ACT_ALLOC, 16'd1,     16'd0,     1'b1, ST_OK,      16'd24, 16'd8},
    '{ACT_ALLOC, 16'd65535, 16'd0,     1'b1, ST_OOM,     16'd0,  16'd0},
    '{ACT_ALLOC, 16'd64,    16'd0,     1'b0, ST_OK,      16'd0,  16'd0},
    '{ACT_ALLOC, 16'd65,    16'd0,     1'b0, ST_OK,      16'd0,  16'd0},
    '{ACT_FREE,  16'd0,     16'd24,    1'b0, ST_OK,      16'd0,  16'd0},
    '{ACT_FREE,  16'd0,     16'd24,    1'b1, ST_DOUBLE,  16'd0,  16'd0},
    '{ACT_FREE,  16'd0,     16'd23,    1'b1, ST_INVALID, 16'd0,  16'd0},
    '{ACT_FREE,  16'd0,     16'hffff,  1'b1, ST_INVALID, 16'd0,  16'd0},
    '{ACT_FREE,  16'd0,     16'd28,    1'b1, ST_INVALID, 16'd0,  16'd0},
    '{ACT_FREE,  16'd0,     16'd56,    1'b0, ST_OK,      16'd0,  16'd0},
    '{ACT_FREE,  16'd0,     16'd24,    1'b0, ST_OK,      16'd0,  16'd0},
    '{ACT_ALLOC, 16'd65512, 16'd0,     1'b0, ST_OK,      16'd0,  16'd0},
    '{ACT_FREE,  16'd0,     16'd144,   1'b0, ST_OK,      16'd0,  16'd0},
    '{ACT_ALLOC, 16'd65512, 16'd0,     1'b0, ST_OK,      16'd0,  16'd0},
    '{ACT_FREE,  16'd0,     16'd24,    1'b0, ST_OK,      16'd0,  16'd0},
    '{ACT_NONE,  16'd0,     16'd0,     1'b1, ST_OK,      16'd0,  16'd0}
  };

  initial begin
    logic [4:0] page_set [];
    int unsigned pick;
    page_set = '{5'd0, 5'd31, 5'd1, 5'd16, 5'd2, 5'd3, 5'd8, 5'd4};
    foreach (blk_live[k]) begin
      blk_size[k] = 0;
      blk_free[k] = 1'b0;
      blk_live[k] = 1'b0;
    end
    heap_len = 0;
    alloc_sum = 0;
    page_cfg = 16;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Walk the directed table at the reset page count
    foreach (plan[n])
      issue(plan[n].action, plan[n].req, plan[n].addr, plan[n].fixed,
            plan[n].status, plan[n].data_offset, plan[n].granted_size);

    // Random phases, each under its own page count
    foreach (page_set[p]) begin
      write_pages((p < 4) ? page_set[p] : 5'($urandom_range(1, 6)));
      issue(ACT_INIT, 16'($urandom), 16'($urandom));
      idle_on = (p != 5);
      for (int n = 0; n < 210; n++) begin
        if (n == 100 && p == 2) drain();
        pick = $urandom_range(99);
        if (pick < 48) random_alloc();
        else if (pick < 88) random_free();
        else if (pick < 95) issue(ACT_INIT, 16'($urandom), 16'($urandom));
        else issue(ACT_NONE, 16'($urandom), 16'($urandom));
      end
    end

    drain();
    repeat (20) @(posedge clk);
    if (!failed && pending_q.size() == 0)
      $display("first_fit_heap_allocator verification clean");
    else
      $display("first_fit_heap_allocator verification failed");
    $finish;
  end

endmodule
